[sv/cc20_pkg.sv]
// Shared types, constants and round functions for the ChaCha20 keystream core.
package cc20_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int CFG_IDX_W = 3;

    typedef logic [15:0][31:0] t_state;
    typedef logic [7:0][31:0]  t_key;
    typedef logic [2:0][31:0]  t_nonce;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY01   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY23   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY45   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY67   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE2  = 3'd5;

    localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32,
                                          32'h3320646e, 32'h61707865};

    function automatic logic [31:0] rotl(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Assemble the cipher state from constants, key, counter and nonce
    function automatic t_state init_state(t_key key, t_nonce nonce, logic [31:0] ctr);
        t_state s;
        s[3:0]   = SIGMA;
        s[11:4]  = key;
        s[12]    = ctr;
        s[15:13] = nonce;
        return s;
    endfunction

    // Half of a column or diagonal round: two add/xor/rotate steps of each
    // of the four quarter rounds, which are independent of one another
    function automatic t_state half_round(t_state s, logic diag, logic second);
        t_state r;
        logic [1:0] qi, qb, qc, qd;
        logic [31:0] a, b, c, d;
        r = s;
        for (int q = 0; q < 4; q++) begin
            qi = 2'(q);
            qb = diag ? qi + 2'd1 : qi;
            qc = diag ? qi + 2'd2 : qi;
            qd = diag ? qi + 2'd3 : qi;
            a = s[{2'd0, qi}];
            b = s[{2'd1, qb}];
            c = s[{2'd2, qc}];
            d = s[{2'd3, qd}];
            a = a + b;
            d = rotl(d ^ a, second ? 8 : 16);
            c = c + d;
            b = rotl(b ^ c, second ? 7 : 12);
            r[{2'd0, qi}] = a;
            r[{2'd1, qb}] = b;
            r[{2'd2, qc}] = c;
            r[{2'd3, qd}] = d;
        end
        return r;
    endfunction

endpackage

[sv/chacha20_block_keystream_core.sv]
// Top level of the ChaCha20 block keystream core: config, round pipeline, output beats.
//
// Each accepted block counter yields one 512-bit ChaCha20 keystream block as eight
// 64-bit beats, pair index 0 to 7, with the last flag on the eighth. The rounds run
// in a pipeline of 4*DOUBLE_ROUNDS register stages (40 for ChaCha20), each holding
// half of a column or diagonal round; the final state add happens as a block is
// loaded into the output register, from which its first beat is offered. New
// counters are accepted while earlier blocks are still in the pipeline; the single
// 64-bit output port sends one block at a time, and the pipeline stalls as a whole
// while a finished block waits for the output register to empty. Key and nonce are
// to be written through the config port only while no block is in flight; the core
// does not enforce this. Writes to index 6 or 7 are ignored.
module chacha20_block_keystream_core #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cc20_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [31:0]                   i_block_counter,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [63:0]                   o_keystream_pair,
    output logic [2:0]                    o_pair_index,
    output logic                          o_last_pair
);
    import cc20_pkg::*;

    t_key        r_key;
    t_nonce      r_nonce;
    t_state      r_ks;
    logic [2:0]  r_idx;
    logic        r_busy;

    logic        pipe_vld;
    t_state      pipe_st;
    logic [31:0] pipe_ctr;
    logic        load_ok;
    logic        load;
    logic        en;
    logic        beat_take;
    t_state      init_out;

    // Config writes, always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_nonce <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KEY01:   r_key[1:0]   <= i_cfg_data;
                REG_KEY23:   r_key[3:2]   <= i_cfg_data;
                REG_KEY45:   r_key[5:4]   <= i_cfg_data;
                REG_KEY67:   r_key[7:6]   <= i_cfg_data;
                REG_NONCE01: r_nonce[1:0] <= i_cfg_data;
                REG_NONCE2:  r_nonce[2]   <= i_cfg_data[31:0];
                default:     ;
            endcase
        end
    end

    // Stall the pipeline only when its last stage cannot hand off
    assign beat_take = r_busy && i_out_ready;
    assign load_ok   = !r_busy || (beat_take && r_idx == 3'd7);
    assign load      = pipe_vld && load_ok;
    assign en        = !pipe_vld || load_ok;
    assign o_in_ready = en;

    cc20_round_pipe #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_state (init_state(r_key, r_nonce, i_block_counter)),
        .i_ctr   (i_block_counter),
        .o_valid (pipe_vld),
        .o_state (pipe_st),
        .o_ctr   (pipe_ctr)
    );

    // Rebuild the initial state for the final add
    assign init_out = init_state(r_key, r_nonce, pipe_ctr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (beat_take) begin
            r_busy <= (r_idx != 3'd7);
            r_idx  <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int i = 0; i < 16; i++) begin
                r_ks[i] <= pipe_st[i] + init_out[i];
            end
        end
    end

    // Drive the current word pair
    assign o_out_valid      = r_busy;
    assign o_keystream_pair = {r_ks[{r_idx, 1'b1}], r_ks[{r_idx, 1'b0}]};
    assign o_pair_index     = r_idx;
    assign o_last_pair      = (r_idx == 3'd7);

`ifndef SYNTH
    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_out_valid && o_pair_index == 3'd0))
        else $error("loaded block does not start at pair zero");

    a_beat_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat_take && r_idx != 3'd7) |=>
            (o_out_valid && o_pair_index == $past(o_pair_index) + 3'd1))
        else $error("pair index did not step after a beat");

    a_hold_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pipe_vld && !en) |=> (pipe_vld && $stable(pipe_ctr)))
        else $error("stalled block left the pipeline");
`endif

endmodule

[sv/cc20_round_pipe.sv]
// Round pipeline: one register stage per half of a column or diagonal round.
module cc20_round_pipe #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  cc20_pkg::t_state i_state,
    input  logic [31:0]      i_ctr,
    output logic             o_valid,
    output cc20_pkg::t_state o_state,
    output logic [31:0]      o_ctr
);
    import cc20_pkg::*;

    localparam int NSTG = 4 * DOUBLE_ROUNDS;

    logic        r_vld [NSTG];
    t_state      r_st  [NSTG];
    logic [31:0] r_ctr [NSTG];

    // Stage s: bit 1 picks column or diagonal, bit 0 picks first or second half
    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        localparam logic DIAG   = ((s / 2) % 2) == 1;
        localparam logic SECOND = (s % 2) == 1;

        logic        n_vld;
        t_state      n_src;
        logic [31:0] n_ctr;

        if (s == 0) begin : g_first
            assign n_vld = i_valid;
            assign n_src = i_state;
            assign n_ctr = i_ctr;
        end else begin : g_next
            assign n_vld = r_vld[s-1];
            assign n_src = r_st[s-1];
            assign n_ctr = r_ctr[s-1];
        end

        // Advance the whole line together when enabled
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= n_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s]  <= half_round(n_src, DIAG, SECOND);
                r_ctr[s] <= n_ctr;
            end
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_state = r_st[NSTG-1];
    assign o_ctr   = r_ctr[NSTG-1];

endmodule

[tb/chacha20_block_keystream_core_tb.sv]
// Testbench for the ChaCha20 block keystream core: self-predicting, random idling, per-beat checks.
`timescale 1ns / 100ps

module chacha20_block_keystream_core_tb;
    import cc20_pkg::*;

    localparam int ROUNDS        = DOUBLE_ROUNDS_DEF;
    localparam int SETTLE_CYCLES = 4 * ROUNDS + 10;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int GAP_MAX       = 18;

    // Index codes past the register list; writes to these are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

    localparam logic [31:0] CONST_EXPA = 32'h61707865;
    localparam logic [31:0] CONST_ND3  = 32'h3320646e;
    localparam logic [31:0] CONST_2BY  = 32'h79622d32;
    localparam logic [31:0] CONST_TEK  = 32'h6b206574;

    typedef struct packed {
        logic [63:0] pair;
        logic [2:0]  index;
        logic        is_last;
    } t_pair_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [31:0]          i_block_counter = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [63:0]          o_keystream_pair;
    logic [2:0]           o_pair_index;
    logic                 o_last_pair;

    // Shadow copy of the key and nonce registers
    t_key       key_shadow = '0;
    t_nonce     nonce_shadow = '0;

    t_pair_beat expected_pairs[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         in_gap_max = GAP_MAX;
    int         out_gap_max = GAP_MAX;

    chacha20_block_keystream_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_block_counter  (i_block_counter),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_keystream_pair (o_keystream_pair),
        .o_pair_index     (o_pair_index),
        .o_last_pair      (o_last_pair)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] rot_left(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic t_state mix_quarter(t_state s, int a, int b, int c, int d);
        s[a] = s[a] + s[b]; s[d] = rot_left(s[d] ^ s[a], 16);
        s[c] = s[c] + s[d]; s[b] = rot_left(s[b] ^ s[c], 12);
        s[a] = s[a] + s[b]; s[d] = rot_left(s[d] ^ s[a], 8);
        s[c] = s[c] + s[d]; s[b] = rot_left(s[b] ^ s[c], 7);
        return s;
    endfunction

    function automatic t_state chacha_block(logic [31:0] ctr);
        t_state start;
        t_state w;
        start[0] = CONST_EXPA;
        start[1] = CONST_ND3;
        start[2] = CONST_2BY;
        start[3] = CONST_TEK;
        for (int i = 0; i < 8; i++)
            start[4 + i] = key_shadow[i];
        start[12] = ctr;
        for (int i = 0; i < 3; i++)
            start[13 + i] = nonce_shadow[i];
        w = start;
        for (int r = 0; r < ROUNDS; r++) begin
            w = mix_quarter(w, 0, 4, 8, 12);
            w = mix_quarter(w, 1, 5, 9, 13);
            w = mix_quarter(w, 2, 6, 10, 14);
            w = mix_quarter(w, 3, 7, 11, 15);
            w = mix_quarter(w, 0, 5, 10, 15);
            w = mix_quarter(w, 1, 6, 11, 12);
            w = mix_quarter(w, 2, 7, 8, 13);
            w = mix_quarter(w, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++)
            w[i] = w[i] + start[i];
        return w;
    endfunction

    // Queue the eight beats of the block for one accepted counter
    function automatic void queue_keystream(logic [31:0] ctr);
        t_state     ks;
        t_pair_beat beat;
        ks = chacha_block(ctr);
        for (int k = 0; k < 8; k++) begin
            beat.pair    = {ks[2 * k + 1], ks[2 * k]};
            beat.index   = 3'(k);
            beat.is_last = (k == 7);
            expected_pairs.insert(expected_pairs.size(), beat);
        end
    endfunction

    function automatic void update_shadow(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        case (idx)
            REG_KEY01: begin
                key_shadow[0] = data[31:0];
                key_shadow[1] = data[63:32];
            end
            REG_KEY23: begin
                key_shadow[2] = data[31:0];
                key_shadow[3] = data[63:32];
            end
            REG_KEY45: begin
                key_shadow[4] = data[31:0];
                key_shadow[5] = data[63:32];
            end
            REG_KEY67: begin
                key_shadow[6] = data[31:0];
                key_shadow[7] = data[63:32];
            end
            REG_NONCE01: begin
                nonce_shadow[0] = data[31:0];
                nonce_shadow[1] = data[63:32];
            end
            REG_NONCE2: begin
                nonce_shadow[2] = data[31:0];
            end
            default: begin
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    // Send one counter; valid stays high afterward so a zero gap keeps streaming
    task automatic send_counter(logic [31:0] ctr);
        int unsigned gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_block_counter <= ctr;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        queue_keystream(ctr);
    endtask

    // Write one register; valid is left high for a following write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        update_shadow(idx, data);
    endtask

    task automatic end_reg_writes();
        i_cfg_valid <= 1'b0;
    endtask

    // Hold off the sender until every queued beat is out, then let the pipe settle
    task automatic drain_keystream();
        i_in_valid <= 1'b0;
        while (expected_pairs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(logic [63:0] k01, logic [63:0] k23, logic [63:0] k45,
                               logic [63:0] k67, logic [63:0] n01, logic [63:0] n2);
        write_reg(REG_KEY01, k01);
        write_reg(REG_KEY23, k23);
        write_reg(REG_KEY45, k45);
        write_reg(REG_KEY67, k67);
        write_reg(REG_NONCE01, n01);
        write_reg(REG_NONCE2, n2);
        end_reg_writes();
    endtask

    // ---------------------------------------------------------------- receiver

    // Stall at random, then check each beat against the oldest expectation
    initial begin : receiver
        int unsigned gap;
        t_pair_beat  want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, out_gap_max);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            if (expected_pairs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: pair %h index %0d last %b",
                             o_keystream_pair, o_pair_index, o_last_pair);
            end else begin
                want = expected_pairs.pop_front();
                if (o_keystream_pair !== want.pair || o_pair_index !== want.index ||
                    o_last_pair !== want.is_last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("beat mismatch: exp pair %h idx %0d last %b, got %h %0d %b",
                                 want.pair, want.index, want.is_last,
                                 o_keystream_pair, o_pair_index, o_last_pair);
                end
            end
        end
    end

    // Watchdog on the cycle count
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    // Zero key and nonce straight out of reset
    task automatic test_reset_key();
        send_counter(32'h0000_0000);
        send_counter(32'h0000_0001);
        send_counter(32'hffff_ffff);
        drain_keystream();
    endtask

    // Standard known-answer key 00..1f with the published nonce
    task automatic test_known_vector();
        load_config({32'h07060504, 32'h03020100}, {32'h0f0e0d0c, 32'h0b0a0908},
                    {32'h17161514, 32'h13121110}, {32'h1f1e1d1c, 32'h1b1a1918},
                    {32'h4a000000, 32'h09000000}, 64'h0);
        send_counter(32'h0000_0001);
        send_counter(32'h0000_0000);
        drain_keystream();
    endtask

    // All-ones key and nonce with extreme counters
    task automatic test_all_ones();
        load_config('1, '1, '1, '1, '1, '1);
        send_counter(32'h0000_0000);
        send_counter(32'hffff_ffff);
        send_counter(32'h8000_0000);
        send_counter(32'h7fff_ffff);
        drain_keystream();
    endtask

    // Spare indexes are dropped; upper bits of the last nonce word are masked
    task automatic test_ignored_writes();
        write_reg(REG_KEY01, '0);
        write_reg(REG_KEY23, '0);
        write_reg(REG_KEY45, '0);
        write_reg(REG_KEY67, '0);
        write_reg(REG_NONCE01, '0);
        write_reg(REG_NONCE2, 64'hffff_ffff_0000_0000);
        write_reg(REG_SPARE6, '1);
        write_reg(REG_SPARE7, '1);
        end_reg_writes();
        send_counter(32'h5555_5555);
        send_counter(32'haaaa_aaaa);
        drain_keystream();
        write_reg(REG_NONCE2, 64'h0000_0000_ffff_ffff);
        end_reg_writes();
        send_counter(32'h1234_5678);
        drain_keystream();
    endtask

    // Random keys and nonces, sequential and random counters, varied idling
    task automatic test_random_stream();
        logic [31:0] base;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase % 4)
                0: begin in_gap_max = GAP_MAX; out_gap_max = GAP_MAX; end
                1: begin in_gap_max = 0;       out_gap_max = 0;       end
                2: begin in_gap_max = GAP_MAX; out_gap_max = 0;       end
                default: begin in_gap_max = 0; out_gap_max = GAP_MAX; end
            endcase
            write_reg(REG_KEY01, {$urandom, $urandom});
            write_reg(REG_KEY23, {$urandom, $urandom});
            write_reg(REG_KEY45, {$urandom, $urandom});
            write_reg(REG_KEY67, {$urandom, $urandom});
            write_reg(REG_NONCE01, {$urandom, $urandom});
            write_reg(REG_NONCE2, {$urandom, $urandom});
            if ($urandom_range(0, 1) == 1)
                write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7,
                          {$urandom, $urandom});
            end_reg_writes();
            base = (phase == 1) ? 32'hffff_fff0 : $urandom;
            for (int i = 0; i < 42; i++) begin
                // pause the sender until every beat so far is out
                if (i == 21 && phase % 2 == 0)
                    drain_keystream();
                if ($urandom_range(0, 1) == 1)
                    send_counter(base + 32'(i));
                else
                    send_counter($urandom);
            end
            drain_keystream();
        end
        in_gap_max  = GAP_MAX;
        out_gap_max = GAP_MAX;
    endtask

    initial begin : main
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_key();
        test_known_vector();
        test_all_ones();
        test_ignored_writes();
        test_random_stream();
        drain_keystream();
        if (mismatch_count == 0 && expected_pairs.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
